/* design/pfrr_pkg.sv */
// Shared types and constants for the per-flow round-robin path spray block.
package pfrr_pkg;

  localparam int PathEntriesDef = 64;
  localparam int FlowEntriesDef = 64;

  localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;

  localparam logic KEY_BY_DEST = 1'b0;
  localparam logic KEY_BY_FLOW = 1'b1;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ROUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_TAG    = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_WEIGHT    = 3'd3,
    ST_LIST_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ROUTE  = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_t;

  // One classified item: data is the path id for an add, the flow key for a route.
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic [6:0]  weight;
    logic [31:0] data;
  } cmd_t;

endpackage

/* design/per_flow_round_robin_path_spray_top.sv */
// Top level of the per-flow round-robin path spray block.
// An item is taken when start is high and busy is low; its result appears on the
// out_ ports for one cycle with out_valid, and the receiver cannot stall it. Items
// pass through a two-entry queue to a back end that works on one item at a time.
// An add-path item writes the path list once per copy of its path id. A route
// item scans the flow table one entry per cycle; on a miss, a random start
// drawn from the LFSR is reduced bit-serially modulo the path count. Rejected
// items and routes on an empty list give their result straight from the idle
// state. The flow table is filled from entry 0 upward and tracked by a fill count,
// so no clearing pass is needed after reset.
module per_flow_round_robin_path_spray_top
  import pfrr_pkg::*;
#(
  parameter int PATH_ENTRIES = PathEntriesDef,
  parameter int FLOW_ENTRIES = FlowEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [6:0]  in_weight,
  input  logic [31:0] in_path_id,
  input  logic [31:0] in_flow_id,
  input  logic        in_flow_tag_present,
  input  logic [31:0] in_dest_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_chosen_path,
  output logic        out_flow_table_full
);

  logic keying_mode_r;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keying_mode_r <= KEY_BY_FLOW;
    end else if (cfg_valid && cfg_ready) begin
      keying_mode_r <= cfg_data;
    end
  end

  pfrr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .keying_mode         (keying_mode_r),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_weight           (in_weight),
    .in_path_id          (in_path_id),
    .in_flow_id          (in_flow_id),
    .in_flow_tag_present (in_flow_tag_present),
    .in_dest_addr        (in_dest_addr),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_pop               (q_pop)
  );

  pfrr_back #(
    .PATH_ENTRIES (PATH_ENTRIES),
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_cmd               (q_cmd),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_chosen_path     (out_chosen_path),
    .out_flow_table_full (out_flow_table_full)
  );

endmodule

/* design/pfrr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/pfrr_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module pfrr_front
  import pfrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        keying_mode,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [6:0]  in_weight,
  input  logic [31:0] in_path_id,
  input  logic [31:0] in_flow_id,
  input  logic        in_flow_tag_present,
  input  logic [31:0] in_dest_addr,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls        = '0;
    cls.weight = in_weight;
    cls.status = ST_OK;
    if (in_action == ACT_ADD) begin
      cls.data = in_path_id;
      if (keying_mode == KEY_BY_DEST && in_weight != 7'd1) begin
        cls.kind   = CMD_REJECT;
        cls.status = ST_WEIGHT;
      end else begin
        cls.kind = CMD_ADD;
      end
    end else begin
      cls.data = (keying_mode == KEY_BY_FLOW) ? in_flow_id : in_dest_addr;
      if (keying_mode == KEY_BY_FLOW && !in_flow_tag_present) begin
        cls.kind   = CMD_REJECT;
        cls.status = ST_NO_TAG;
      end else begin
        cls.kind = CMD_ROUTE;
      end
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

/* design/pfrr_back.sv */
// Back end: path list fill, flow table scan, random start division and result.
module pfrr_back
  import pfrr_pkg::*;
#(
  parameter int PATH_ENTRIES = PathEntriesDef,
  parameter int FLOW_ENTRIES = FlowEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_chosen_path,
  output logic        out_flow_table_full
);

  localparam int PAW  = $clog2(PATH_ENTRIES);
  localparam int PCW  = $clog2(PATH_ENTRIES + 1);
  localparam int FAW  = $clog2(FLOW_ENTRIES);
  localparam int FCW  = $clog2(FLOW_ENTRIES + 1);
  localparam int SUMW = ((PCW > 7) ? PCW : 7) + 1;
  localparam int FW   = 32 + PAW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DIV   = 6'b001000,
    S_PATH  = 6'b010000,
    S_PWAIT = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [PCW-1:0] count_r, count_nxt;
  logic [FCW-1:0] fill_r, fill_nxt;
  logic [31:0]    lfsr_r, lfsr_nxt;
  logic [6:0]     wcnt_r, wcnt_nxt;
  logic [FCW-1:0] scan_r, scan_nxt;
  logic           pend_r, pend_nxt;
  logic [FAW-1:0] paddr_r, paddr_nxt;
  logic           hit_r, hit_nxt;
  logic [FAW-1:0] hit_addr_r, hit_addr_nxt;
  logic [PAW-1:0] idx_r, idx_nxt;
  logic [PCW-1:0] rem_r, rem_nxt;
  logic [31:0]    div_r, div_nxt;
  logic [4:0]     bit_r, bit_nxt;
  logic           full_r, full_nxt;

  logic           out_valid_r, out_valid_nxt;
  status_t        out_status_r, out_status_nxt;
  logic [31:0]    out_path_r, out_path_nxt;
  logic           out_full_r, out_full_nxt;

  logic            p_we, p_re;
  logic [PAW-1:0]  p_waddr;
  logic [31:0]     p_rdata;
  logic            f_we, f_re;
  logic [FAW-1:0]  f_waddr, f_raddr;
  logic [FW-1:0]   f_wdata, f_rdata;

  logic [SUMW-1:0] sum;
  logic [PCW:0]    trial;
  logic [PCW-1:0]  idx_inc;
  logic [PAW-1:0]  idx_wrap;
  logic [31:0]     lfsr_adv;
  logic            rd_issue;

  pfrr_ram #(.WIDTH(32), .DEPTH(PATH_ENTRIES)) u_path_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (cmd_r.data),
    .re    (p_re),
    .raddr (idx_r),
    .rdata (p_rdata)
  );

  pfrr_ram #(.WIDTH(FW), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  assign sum      = SUMW'(count_r) + SUMW'(q_cmd.weight);
  assign trial    = {rem_r, div_r[31]};
  assign idx_inc  = PCW'(idx_r) + PCW'(1);
  assign idx_wrap = (idx_inc == count_r) ? '0 : idx_inc[PAW-1:0];
  assign lfsr_adv = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : 32'd0);
  assign rd_issue = (state_r == S_SCAN) && (scan_r < fill_r);
  assign p_waddr  = PAW'(count_r + PCW'(wcnt_r));
  assign f_raddr  = scan_r[FAW-1:0];
  assign f_re     = rd_issue;
  assign f_wdata  = {cmd_r.data, idx_wrap};
  assign f_waddr  = hit_r ? hit_addr_r : fill_r[FAW-1:0];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    lfsr_nxt       = lfsr_r;
    wcnt_nxt       = wcnt_r;
    scan_nxt       = scan_r;
    pend_nxt       = 1'b0;
    paddr_nxt      = paddr_r;
    hit_nxt        = hit_r;
    hit_addr_nxt   = hit_addr_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    bit_nxt        = bit_r;
    full_nxt       = full_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_path_nxt   = out_path_r;
    out_full_nxt   = out_full_r;
    q_pop          = 1'b0;
    p_we           = 1'b0;
    p_re           = 1'b0;
    f_we           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_cmd;
          out_path_nxt = '0;
          out_full_nxt = 1'b0;
          case (q_cmd.kind)
            CMD_REJECT: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = q_cmd.status;
            end
            CMD_ADD: begin
              if (sum > SUMW'(PATH_ENTRIES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_LIST_FULL;
              end else if (q_cmd.weight == 7'd0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_OK;
              end else begin
                wcnt_nxt  = '0;
                state_nxt = S_FILL;
              end
            end
            CMD_ROUTE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_FILL: begin
        p_we     = 1'b1;
        wcnt_nxt = wcnt_r + 7'd1;
        if (wcnt_r + 7'd1 == cmd_r.weight) begin
          count_nxt      = count_r + PCW'(cmd_r.weight);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        pend_nxt  = rd_issue;
        paddr_nxt = scan_r[FAW-1:0];
        if (rd_issue) begin
          scan_nxt = scan_r + FCW'(1);
        end
        if (pend_r && f_rdata[FW-1:PAW] == cmd_r.data) begin
          hit_nxt      = 1'b1;
          hit_addr_nxt = paddr_r;
          idx_nxt      = f_rdata[PAW-1:0];
          state_nxt    = S_PATH;
        end else if (!rd_issue && !pend_r) begin
          // miss: draw the random start and reduce it modulo the path count
          hit_nxt   = 1'b0;
          lfsr_nxt  = lfsr_adv;
          div_nxt   = lfsr_adv;
          rem_nxt   = '0;
          bit_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, count_r}) begin
          rem_nxt = PCW'(trial - {1'b0, count_r});
        end else begin
          rem_nxt = trial[PCW-1:0];
        end
        div_nxt = div_r << 1;
        bit_nxt = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          idx_nxt   = rem_nxt[PAW-1:0];
          state_nxt = S_PATH;
        end
      end
      S_PATH: begin
        p_re     = 1'b1;
        full_nxt = 1'b0;
        if (hit_r) begin
          f_we = 1'b1;
        end else if (fill_r < FCW'(FLOW_ENTRIES)) begin
          f_we     = 1'b1;
          fill_nxt = fill_r + FCW'(1);
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_path_nxt   = p_rdata;
        out_full_nxt   = full_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fill_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      lfsr_r      <= lfsr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    wcnt_r       <= wcnt_nxt;
    scan_r       <= scan_nxt;
    paddr_r      <= paddr_nxt;
    hit_r        <= hit_nxt;
    hit_addr_r   <= hit_addr_nxt;
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    bit_r        <= bit_nxt;
    full_r       <= full_nxt;
    out_status_r <= out_status_nxt;
    out_path_r   <= out_path_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_chosen_path     = out_path_r;
  assign out_flow_table_full = out_full_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= PCW'(PATH_ENTRIES))
    else $error("path count above list size");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r <= FCW'(FLOW_ENTRIES))
    else $error("flow fill above table size");
  a_err_nopath: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && out_status_r != ST_OK |-> out_path_r == '0 && !out_full_r)
    else $error("error result carries a path");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
      q_pop |-> state_r == S_IDLE)
    else $error("queue popped while back end busy");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the per-flow round-robin path spray block.
module testbench
  import pfrr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATH_N = PathEntriesDef;
  localparam int FLOW_N = FlowEntriesDef;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 200;

  typedef enum logic [1:0] {
    Q_ITEM,
    Q_CFG,
    Q_DRAIN
  } queue_kind_t;

  typedef struct {
    queue_kind_t kind;
    int          idle_pct;
    logic        action;
    logic [6:0]  weight;
    logic [31:0] path_id;
    logic [31:0] flow_id;
    logic        tag;
    logic [31:0] dest;
    logic        mode;
  } pending_t;

  typedef struct {
    status_t     status;
    logic [31:0] path;
    logic        full;
  } route_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [6:0]  in_weight = '0;
  logic [31:0] in_path_id = '0;
  logic [31:0] in_flow_id = '0;
  logic        in_flow_tag_present = 1'b0;
  logic [31:0] in_dest_addr = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_chosen_path;
  logic        out_flow_table_full;

  per_flow_round_robin_path_spray_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_action           (in_action),
    .in_weight           (in_weight),
    .in_path_id          (in_path_id),
    .in_flow_id          (in_flow_id),
    .in_flow_tag_present (in_flow_tag_present),
    .in_dest_addr        (in_dest_addr),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_chosen_path     (out_chosen_path),
    .out_flow_table_full (out_flow_table_full)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Shadow copy of the block's state
  logic [31:0]   spray_list [PATH_N];
  int unsigned   spray_len = 0;
  logic [31:0]   flow_key_tab [FLOW_N];
  bit            flow_used [FLOW_N];
  int unsigned   flow_next [FLOW_N];
  logic [31:0]   start_lfsr = LFSR_SEED;
  logic          key_mode = KEY_BY_FLOW;

  pending_t      pending_q[$];
  route_result_t expected_q[$];
  logic [31:0]   key_pool[48];
  int            mismatches = 0;
  int            quiet_cycles = 0;
  int            stall_cycles = 0;
  bit            timed_out = 1'b0;

  function automatic route_result_t spray_predict(pending_t e);
    route_result_t r;
    logic [31:0]   key;
    int            hit;
    int            free_slot;
    int unsigned   idx;
    r = '{ST_OK, 32'd0, 1'b0};
    if (e.action == ACT_ADD) begin
      if (e.weight != 7'd1 && key_mode != KEY_BY_FLOW) begin
        r.status = ST_WEIGHT;
      end else if (spray_len + e.weight > PATH_N) begin
        r.status = ST_LIST_FULL;
      end else begin
        for (int i = 0; i < e.weight; i++) spray_list[spray_len + i] = e.path_id;
        spray_len += e.weight;
      end
      return r;
    end
    if (key_mode == KEY_BY_FLOW) begin
      if (!e.tag) begin
        r.status = ST_NO_TAG;
        return r;
      end
      key = e.flow_id;
    end else begin
      key = e.dest;
    end
    if (spray_len == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < FLOW_N; i++) begin
      if (flow_used[i]) begin
        if (hit < 0 && flow_key_tab[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      idx = flow_next[hit] % spray_len;
    end else begin
      // Galois shift, then use the shifted value
      start_lfsr = start_lfsr[0] ? ((start_lfsr >> 1) ^ LFSR_TAPS) : (start_lfsr >> 1);
      idx = start_lfsr % spray_len;
    end
    r.path = spray_list[idx];
    if (hit >= 0) begin
      flow_next[hit] = (idx + 1) % spray_len;
    end else if (free_slot >= 0) begin
      flow_used[free_slot] = 1'b1;
      flow_key_tab[free_slot] = key;
      flow_next[free_slot] = (idx + 1) % spray_len;
    end else begin
      r.full = 1'b1;
    end
    return r;
  endfunction

  function automatic void push_item(int idle, logic act, logic [6:0] w, logic [31:0] pid,
                                    logic [31:0] fid, logic tag, logic [31:0] dst);
    pending_q.insert(pending_q.size(), '{Q_ITEM, idle, act, w, pid, fid, tag, dst, 1'b0});
  endfunction

  function automatic void push_cfg(logic mode);
    pending_q.insert(pending_q.size(),
                     '{Q_CFG, 0, 1'b0, 7'd0, 32'd0, 32'd0, 1'b0, 32'd0, mode});
  endfunction

  function automatic void push_drain();
    pending_q.insert(pending_q.size(),
                     '{Q_DRAIN, 0, 1'b0, 7'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0});
  endfunction

  function automatic void push_random(int idle, int count);
    logic [6:0]  w;
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) push_drain();
      w = ($urandom_range(99) < 70) ? 7'd1 : 7'($urandom_range(127));
      k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(47)] : $urandom;
      if ($urandom_range(99) < 15) begin
        push_item(idle, ACT_ADD, w, $urandom, $urandom, 1'($urandom), $urandom);
      end else if ($urandom_range(1)) begin
        push_item(idle, ACT_ROUTE, 7'($urandom), $urandom, k,
                  $urandom_range(99) < 90, $urandom);
      end else begin
        push_item(idle, ACT_ROUTE, 7'($urandom), $urandom, $urandom,
                  $urandom_range(99) < 90, k);
      end
    end
  endfunction

  // Driver: one nonblocking update per signal per edge
  always @(posedge clk) begin
    pending_t      head;
    route_result_t r;
    logic          nxt_start;
    logic          nxt_cfg;
    nxt_start = 1'b0;
    nxt_cfg = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        r = spray_predict(pending_q[0]);
        expected_q.insert(expected_q.size(), r);
        void'(pending_q.pop_front());
      end
      if (cfg_valid && cfg_ready) begin
        key_mode = pending_q[0].mode;
        void'(pending_q.pop_front());
      end
      if (start && busy) begin
        nxt_start = 1'b1;
      end else if (cfg_valid && !cfg_ready) begin
        nxt_cfg = 1'b1;
      end else if (pending_q.size() > 0) begin
        head = pending_q[0];
        case (head.kind)
          Q_ITEM: begin
            if ($urandom_range(99) >= head.idle_pct) begin
              nxt_start = 1'b1;
              in_action <= head.action;
              in_weight <= head.weight;
              in_path_id <= head.path_id;
              in_flow_id <= head.flow_id;
              in_flow_tag_present <= head.tag;
              in_dest_addr <= head.dest;
            end
          end
          Q_CFG: begin
            // write only once the block has gone quiet
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nxt_cfg = 1'b1;
              cfg_data <= head.mode;
            end
          end
          default: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(pending_q.pop_front());
          end
        endcase
      end
      quiet_cycles = (expected_q.size() == 0 && !start && !busy) ? quiet_cycles + 1 : 0;
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // Monitor
  always @(posedge clk) begin
    route_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d path=%h full=%b",
                   out_status, out_chosen_path, out_flow_table_full);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_status !== exp_r.status || out_chosen_path !== exp_r.path ||
            out_flow_table_full !== exp_r.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected status=%0d path=%h full=%b, ",
                      "got status=%0d path=%h full=%b"},
                     exp_r.status, exp_r.path, exp_r.full,
                     out_status, out_chosen_path, out_flow_table_full);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || quiet_cycles > 0)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 48; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;

    // Directed: per-destination mode on an empty list first
    push_cfg(KEY_BY_DEST);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'd0, 1'b0, 32'h1234_5678);
    push_item(0, ACT_ADD, 7'd2, 32'hDEAD_BEEF, 32'd0, 1'b0, 32'd0);
    push_cfg(KEY_BY_FLOW);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'h55, 1'b0, 32'd0);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'h55, 1'b1, 32'd0);
    push_item(0, ACT_ADD, 7'd0, 32'h1111_1111, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ADD, 7'd1, 32'h0000_0000, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ADD, 7'd64, 32'h2222_2222, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ADD, 7'd127, 32'h3333_3333, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ADD, 7'd3, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ADD, 7'd2, 32'hA5A5_5A5A, 32'd0, 1'b1, 32'd0);
    for (int i = 0; i < 4; i++) begin
      push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'h0000_0000, 1'b1, 32'd0);
      push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    end
    push_cfg(KEY_BY_DEST);
    push_item(0, ACT_ADD, 7'd1, 32'h7777_0001, 32'd0, 1'b0, 32'd0);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'd0, 1'b0, 32'h0000_0000);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    push_item(0, ACT_ROUTE, 7'd0, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF);

    // Random phases: sender idles often, very often, then never
    push_random(22, 550);
    push_cfg(KEY_BY_FLOW);
    push_random(61, 550);
    push_cfg(KEY_BY_DEST);
    push_random(0, 275);
    push_cfg(KEY_BY_FLOW);
    push_random(0, 275);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || expected_q.size() > 0 || start || cfg_valid)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
